>>> design/vss_pkg.sv
package vss_pkg;

    // Grid geometry.
    localparam int GRID_SIZE = 32;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int N_W       = $clog2(GRID_SIZE + 1);
    localparam int VOX_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(VOX_COUNT);

    // Distance datapath widths.
    localparam int MAG_W  = 33 + IDX_W;
    localparam int SUM_W  = 2 * MAG_W + 2;
    localparam int ROOT_W = MAG_W + 1;
    localparam int SDF_W  = ROOT_W + 1;
    localparam int SH_W   = ROOT_W - 32;
    localparam int FULL_W = ROOT_W + 32;

    // Divider widths.
    localparam int DIVD_W = 49;
    localparam int DIVS_W = 31;

    // Region bound width.
    localparam int BND_W = 37;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_BOX    = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_CELL_X   = 3'd3;
    localparam logic [2:0] REG_CELL_Y   = 3'd4;
    localparam logic [2:0] REG_CELL_Z   = 3'd5;
    localparam logic [2:0] REG_GRID     = 3'd6;

endpackage

>>> design/vss_div.sv
module vss_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vss_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [vss_pkg::DIVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [vss_pkg::DIVD_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(vss_pkg::DIVD_W + 1);

    logic [vss_pkg::DIVD_W-1:0] r_n;
    logic [vss_pkg::DIVS_W-1:0] r_rem;
    logic [vss_pkg::DIVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [vss_pkg::DIVS_W:0] rem2;
    logic [vss_pkg::DIVS_W:0] diff;
    logic                     ge;

    assign rem2 = {r_rem, r_n[vss_pkg::DIVD_W-1]};
    assign diff = rem2 - {1'b0, r_dvs};
    assign ge   = rem2 >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(vss_pkg::DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division: dividend bits leave at the top while quotient
    // bits enter at the bottom of the same shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_n   <= {r_n[vss_pkg::DIVD_W-2:0], ge};
            r_rem <= ge ? diff[vss_pkg::DIVS_W-1:0] : rem2[vss_pkg::DIVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_n;

endmodule

>>> design/vss_sqrt.sv
module vss_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vss_pkg::SUM_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [vss_pkg::ROOT_W-1:0]  o_root
);

    localparam int REM_W = vss_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(vss_pkg::ROOT_W + 1);

    logic [vss_pkg::SUM_W-1:0]  r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [vss_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem2  = {r_rem[REM_W-3:0], r_rad[vss_pkg::SUM_W-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(vss_pkg::ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One root bit per cycle, two radicand bits shifted in each step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[vss_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= ge ? (rem2 - trial) : rem2;
            r_root <= {r_root[vss_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> design/voxel_sdf_sphere_sculpt.sv
// After reset the voxel memory is swept to 1.0, one entry a cycle;
// the block takes no item during that pass. Configuration resets to its defaults.
// Read, write, box and clear items go from decode to output, an in-range read by way of
// a memory read. A sphere item runs four divisions of a 49-bit dividend, then visits each
// voxel of its region through the shared 32x32 multiplier and the bit-serial square root.
// One item is in work at a time; the finished result waits in an output register.
module voxel_sdf_sphere_sculpt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vss_pkg::CFG_AW-1:0]           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0]                           i_opcode,
    input  logic signed [31:0]                   i_center_x,
    input  logic signed [31:0]                   i_center_y,
    input  logic signed [31:0]                   i_center_z,
    input  logic [30:0]                          i_radius,
    input  logic signed [31:0]                   i_strength,
    input  logic signed [15:0]                   i_voxel_x,
    input  logic signed [15:0]                   i_voxel_y,
    input  logic signed [15:0]                   i_voxel_z,
    input  logic signed [31:0]                   i_write_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [31:0]                   o_read_value,
    output logic                                 o_dirty_valid,
    output logic signed [15:0]                   o_dirty_min_x,
    output logic signed [15:0]                   o_dirty_min_y,
    output logic signed [15:0]                   o_dirty_min_z,
    output logic signed [15:0]                   o_dirty_max_x,
    output logic signed [15:0]                   o_dirty_max_y,
    output logic signed [15:0]                   o_dirty_max_z
);

    localparam int IDX_W  = vss_pkg::IDX_W;
    localparam int ADDR_W = vss_pkg::ADDR_W;
    localparam int N_W    = vss_pkg::N_W;
    localparam int MAG_W  = vss_pkg::MAG_W;
    localparam int D_W    = MAG_W + 1;
    localparam int SUM_W  = vss_pkg::SUM_W;
    localparam int ROOT_W = vss_pkg::ROOT_W;
    localparam int SDF_W  = vss_pkg::SDF_W;
    localparam int SH_W   = vss_pkg::SH_W;
    localparam int FULL_W = vss_pkg::FULL_W;
    localparam int BND_W  = vss_pkg::BND_W;
    localparam int DIVD_W = vss_pkg::DIVD_W;
    localparam int DIVS_W = vss_pkg::DIVS_W;
    localparam int Q_W    = FULL_W - 16;

    localparam logic [4:0] ST_CLR   = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_DEC   = 5'd2;
    localparam logic [4:0] ST_RD    = 5'd3;
    localparam logic [4:0] ST_DIV   = 5'd4;
    localparam logic [4:0] ST_DIVW  = 5'd5;
    localparam logic [4:0] ST_BOUND = 5'd6;
    localparam logic [4:0] ST_POS   = 5'd7;
    localparam logic [4:0] ST_MUL   = 5'd8;
    localparam logic [4:0] ST_ACC   = 5'd9;
    localparam logic [4:0] ST_SQ    = 5'd10;
    localparam logic [4:0] ST_SQW   = 5'd11;
    localparam logic [4:0] ST_SDF   = 5'd12;
    localparam logic [4:0] ST_SC0   = 5'd13;
    localparam logic [4:0] ST_SC1   = 5'd14;
    localparam logic [4:0] ST_SC2   = 5'd15;
    localparam logic [4:0] ST_UPD   = 5'd16;
    localparam logic [4:0] ST_DIRTY = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    function automatic logic signed [35:0] trunc16(input logic signed [51:0] v);
        logic signed [51:0] m;
        m = -v;
        if (v < 0) begin
            return -$signed(m[51:16]);
        end
        return v[51:16];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [BND_W-1:0] v);
        if (v < -32768) begin
            return 16'sh8000;
        end
        if (v > 32767) begin
            return 16'sh7fff;
        end
        return v[15:0];
    endfunction

    function automatic logic [30:0] nz(input logic [30:0] c);
        return (c == 31'd0) ? 31'd1 : c;
    endfunction

    // Configuration registers.
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic [30:0]        r_cell_x, r_cell_y, r_cell_z;
    logic [5:0]         r_gsize;

    // Control.
    logic [4:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic              r_ovalid;
    logic              r_dflag;
    logic signed [15:0] r_dlo [3];
    logic signed [15:0] r_dhi [3];

    // Captured item.
    logic [2:0]         r_op;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic signed [31:0] r_str;
    logic signed [15:0] r_vx, r_vy, r_vz;
    logic signed [31:0] r_wv;

    // Datapath.
    logic [1:0]               r_k, r_ax, r_pt;
    logic [DIVD_W-1:0]        r_gr;
    logic signed [DIVD_W:0]   r_gc [3];
    logic signed [BND_W-1:0]  r_lo [3];
    logic signed [BND_W-1:0]  r_hi [3];
    logic [IDX_W-1:0]         r_ix, r_iy, r_iz;
    logic [MAG_W-1:0]         r_mag;
    logic [SUM_W-1:0]         r_acc;
    logic [ROOT_W-1:0]        r_dist;
    logic                     r_sneg;
    logic [ROOT_W-1:0]        r_smag;
    logic [63:0]              r_prod;
    logic [63:0]              r_full;
    logic signed [31:0]       r_v;
    logic signed [31:0]       r_rv;

    logic [31:0]              r_mem [vss_pkg::VOX_COUNT];
    logic signed [31:0]       r_mem_q;

    // Combinational.
    logic                    cfg_wr;
    logic [N_W-1:0]          n_used;
    logic                    inb;
    logic [ADDR_W-1:0]       vox_addr, cur_addr, mem_raddr, mem_waddr;
    logic                    mem_we;
    logic [31:0]             mem_wdata;
    logic                    out_free;
    logic                    is_last, better, empty;
    logic [31:0]             mul_a, mul_b, s_mag;
    logic signed [32:0]      cdiff;
    logic [32:0]             cmag;
    logic [DIVD_W-1:0]       div_dvd;
    logic [DIVS_W-1:0]       div_dvs;
    logic                    div_done;
    logic [DIVD_W-1:0]       div_q;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic signed [BND_W-1:0] bnd_lo [3];
    logic signed [BND_W-1:0] bnd_hi [3];
    logic signed [BND_W-1:0] nm1;
    logic [IDX_W-1:0]        sel_idx;
    logic signed [31:0]      sel_org, sel_cen;
    logic [30:0]             sel_cell;
    logic [IDX_W+30:0]       pos_off;
    logic signed [D_W-1:0]   pos_diff;
    logic [SUM_W-1:0]        acc_add;
    logic signed [SDF_W-1:0] sdf0, sdf;
    logic [FULL_W-1:0]       full;
    logic [Q_W-1:0]          q_w;
    logic [31:0]             lim, q32;
    logic                    sneg_c;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        case (paddr[4:2])
            vss_pkg::REG_ORIGIN_X: prdata = r_org_x;
            vss_pkg::REG_ORIGIN_Y: prdata = r_org_y;
            vss_pkg::REG_ORIGIN_Z: prdata = r_org_z;
            vss_pkg::REG_CELL_X:   prdata = {1'b0, r_cell_x};
            vss_pkg::REG_CELL_Y:   prdata = {1'b0, r_cell_y};
            vss_pkg::REG_CELL_Z:   prdata = {1'b0, r_cell_z};
            vss_pkg::REG_GRID:     prdata = {26'd0, r_gsize};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_z  <= '0;
            r_cell_x <= 31'd2114;
            r_cell_y <= 31'd2114;
            r_cell_z <= 31'd2114;
            r_gsize  <= 6'd32;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                vss_pkg::REG_ORIGIN_X: r_org_x  <= pwdata;
                vss_pkg::REG_ORIGIN_Y: r_org_y  <= pwdata;
                vss_pkg::REG_ORIGIN_Z: r_org_z  <= pwdata;
                vss_pkg::REG_CELL_X:   r_cell_x <= pwdata[30:0];
                vss_pkg::REG_CELL_Y:   r_cell_y <= pwdata[30:0];
                vss_pkg::REG_CELL_Z:   r_cell_z <= pwdata[30:0];
                vss_pkg::REG_GRID:     r_gsize  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Size in use; a size of zero leaves every index out of bounds.
    assign n_used = (int'(r_gsize) > vss_pkg::GRID_SIZE) ? N_W'(vss_pkg::GRID_SIZE)
                                                          : N_W'(r_gsize);
    assign nm1 = BND_W'(n_used) - BND_W'(1);

    assign inb = !r_vx[15] && !r_vy[15] && !r_vz[15]
              && ($unsigned(r_vx) < 16'(n_used))
              && ($unsigned(r_vy) < 16'(n_used))
              && ($unsigned(r_vz) < 16'(n_used));

    assign vox_addr = ADDR_W'(ADDR_W'(r_vz[IDX_W-1:0]) *
                              ADDR_W'(vss_pkg::GRID_SIZE * vss_pkg::GRID_SIZE)
                            + ADDR_W'(r_vy[IDX_W-1:0]) * ADDR_W'(vss_pkg::GRID_SIZE)
                            + ADDR_W'(r_vx[IDX_W-1:0]));
    assign cur_addr = ADDR_W'(ADDR_W'(r_iz) *
                              ADDR_W'(vss_pkg::GRID_SIZE * vss_pkg::GRID_SIZE)
                            + ADDR_W'(r_iy) * ADDR_W'(vss_pkg::GRID_SIZE)
                            + ADDR_W'(r_ix));
    assign mem_raddr = (r_op inside {vss_pkg::OP_ADD, vss_pkg::OP_SUB}) ? cur_addr : vox_addr;

    // Divider operands: step 0 scales the radius, steps 1 to 3 the centre axes.
    always_comb begin
        case (r_k)
            2'd1:    cdiff = {r_cx[31], r_cx} - {r_org_x[31], r_org_x};
            2'd2:    cdiff = {r_cy[31], r_cy} - {r_org_y[31], r_org_y};
            default: cdiff = {r_cz[31], r_cz} - {r_org_z[31], r_org_z};
        endcase
        cmag = cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
        case (r_k)
            2'd0: begin
                div_dvd = {2'b00, r_rad, 16'd0};
                div_dvs = nz(r_cell_x);
            end
            2'd1: begin
                div_dvd = {cmag, 16'd0};
                div_dvs = nz(r_cell_x);
            end
            2'd2: begin
                div_dvd = {cmag, 16'd0};
                div_dvs = nz(r_cell_y);
            end
            default: begin
                div_dvd = {cmag, 16'd0};
                div_dvs = nz(r_cell_z);
            end
        endcase
    end

    vss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIV),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    vss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_SQ),
        .i_radicand (r_acc),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Region bounds, padded by one voxel and clamped to the grid.
    always_comb begin
        logic signed [51:0] t_gc, t_gr;
        empty = 1'b0;
        t_gr  = 52'(r_gr);
        for (int k = 0; k < 3; k++) begin
            t_gc = 52'(r_gc[k]);
            bnd_lo[k] = BND_W'(trunc16(t_gc - t_gr)) - BND_W'(1);
            bnd_hi[k] = BND_W'(trunc16(t_gc + t_gr)) + BND_W'(1);
            if (bnd_lo[k] < 0) begin
                bnd_lo[k] = '0;
            end
            if (bnd_hi[k] > nm1) begin
                bnd_hi[k] = nm1;
            end
            if (bnd_lo[k] > bnd_hi[k]) begin
                empty = 1'b1;
            end
        end
    end

    // World offset of the current voxel from the centre along one axis.
    always_comb begin
        case (r_ax)
            2'd0: begin
                sel_idx = r_ix; sel_org = r_org_x; sel_cen = r_cx; sel_cell = nz(r_cell_x);
            end
            2'd1: begin
                sel_idx = r_iy; sel_org = r_org_y; sel_cen = r_cy; sel_cell = nz(r_cell_y);
            end
            default: begin
                sel_idx = r_iz; sel_org = r_org_z; sel_cen = r_cz; sel_cell = nz(r_cell_z);
            end
        endcase
        pos_off  = (IDX_W+31)'(sel_idx) * (IDX_W+31)'(sel_cell);
        pos_diff = D_W'(sel_org) + $signed(D_W'(pos_off)) - D_W'(sel_cen);
    end

    assign s_mag = r_str[31] ? (32'd0 - r_str) : r_str;

    // Operand selection for the shared 32x32 multiplier.
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            ST_MUL: begin
                case (r_pt)
                    2'd0: begin
                        mul_a = r_mag[31:0];
                        mul_b = r_mag[31:0];
                    end
                    2'd1: begin
                        mul_a = r_mag[31:0];
                        mul_b = 32'(r_mag[MAG_W-1:32]);
                    end
                    default: begin
                        mul_a = 32'(r_mag[MAG_W-1:32]);
                        mul_b = 32'(r_mag[MAG_W-1:32]);
                    end
                endcase
            end
            ST_SC0: begin
                mul_a = r_smag[31:0];
                mul_b = s_mag;
            end
            ST_SC1: begin
                mul_a = 32'(r_smag[ROOT_W-1:32]);
                mul_b = s_mag;
            end
            default: ;
        endcase
    end

    // Square of a split magnitude: low*low + 2*low*high<<32 + high*high<<64.
    always_comb begin
        case (r_pt)
            2'd0:    acc_add = SUM_W'(r_prod);
            2'd1:    acc_add = SUM_W'(r_prod) << 33;
            default: acc_add = SUM_W'(r_prod) << 64;
        endcase
    end

    always_comb begin
        sdf0 = $signed({1'b0, r_dist}) - $signed(SDF_W'(r_rad));
        sdf  = (r_op == vss_pkg::OP_SUB) ? -sdf0 : sdf0;
        sneg_c = sdf[SDF_W-1] != r_str[31];
    end

    always_comb begin
        full = FULL_W'(r_full) + (FULL_W'(r_prod) << 32);
        q_w  = full[FULL_W-1:16];
        lim  = r_sneg ? 32'h8000_0000 : 32'h7fff_ffff;
        q32  = (q_w > Q_W'(lim)) ? lim : q_w[31:0];
    end

    assign better  = (r_op == vss_pkg::OP_SUB) ? (r_v > r_mem_q) : (r_v < r_mem_q);
    assign is_last = (r_ix == r_hi[0][IDX_W-1:0]) && (r_iy == r_hi[1][IDX_W-1:0])
                  && (r_iz == r_hi[2][IDX_W-1:0]);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = r_v;
        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = vss_pkg::ONE_Q16;
            end
            ST_DEC: begin
                mem_we    = (r_op == vss_pkg::OP_WRITE) && inb;
                mem_waddr = vox_addr;
                mem_wdata = r_wv;
            end
            ST_UPD: mem_we = better;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:   if (r_clr == ADDR_W'(vss_pkg::VOX_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_DEC;
            ST_DEC: begin
                if (r_op inside {vss_pkg::OP_ADD, vss_pkg::OP_SUB}) begin
                    n_state = ST_DIV;
                end else if (r_op == vss_pkg::OP_READ && inb) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_RD:    n_state = ST_OUT;
            ST_DIV:   n_state = ST_DIVW;
            ST_DIVW:  if (div_done) n_state = (r_k == 2'd3) ? ST_BOUND : ST_DIV;
            ST_BOUND: n_state = empty ? ST_DIRTY : ST_POS;
            ST_POS:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC: begin
                if (r_pt != 2'd2) begin
                    n_state = ST_MUL;
                end else if (r_ax != 2'd2) begin
                    n_state = ST_POS;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ:    n_state = ST_SQW;
            ST_SQW:   if (sq_done) n_state = ST_SDF;
            ST_SDF:   n_state = ST_SC0;
            ST_SC0:   n_state = ST_SC1;
            ST_SC1:   n_state = ST_SC2;
            ST_SC2:   n_state = ST_UPD;
            ST_UPD:   n_state = is_last ? ST_DIRTY : ST_POS;
            ST_DIRTY: n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_dflag  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_dlo[k] <= '0;
                r_dhi[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_DEC && r_op == vss_pkg::OP_CLEAR) begin
                r_dflag <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_dlo[k] <= '0;
                    r_dhi[k] <= '0;
                end
            end
            // A region that missed the grid still merges its inverted bounds.
            if (r_state == ST_DIRTY) begin
                r_dflag <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (!r_dflag || sat16(r_lo[k]) < r_dlo[k]) begin
                        r_dlo[k] <= sat16(r_lo[k]);
                    end
                    if (!r_dflag || sat16(r_hi[k]) > r_dhi[k]) begin
                        r_dhi[k] <= sat16(r_hi[k]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_op  <= i_opcode;
                r_cx  <= i_center_x;
                r_cy  <= i_center_y;
                r_cz  <= i_center_z;
                r_rad <= i_radius;
                r_str <= i_strength;
                r_vx  <= i_voxel_x;
                r_vy  <= i_voxel_y;
                r_vz  <= i_voxel_z;
                r_wv  <= i_write_value;
            end
            ST_DEC: begin
                r_k <= 2'd0;
                if (r_op == vss_pkg::OP_READ || r_op == vss_pkg::OP_WRITE) begin
                    r_rv <= inb ? r_wv : vss_pkg::ONE_Q16;
                end else begin
                    r_rv <= '0;
                end
            end
            ST_RD: r_rv <= r_mem_q;
            ST_DIVW: begin
                if (div_done) begin
                    r_k <= r_k + 2'd1;
                    case (r_k)
                        2'd0:    r_gr <= div_q;
                        2'd1:    r_gc[0] <= cdiff[32] ? -$signed({1'b0, div_q})
                                                      : $signed({1'b0, div_q});
                        2'd2:    r_gc[1] <= cdiff[32] ? -$signed({1'b0, div_q})
                                                      : $signed({1'b0, div_q});
                        default: r_gc[2] <= cdiff[32] ? -$signed({1'b0, div_q})
                                                      : $signed({1'b0, div_q});
                    endcase
                end
            end
            ST_BOUND: begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[k] <= bnd_lo[k];
                    r_hi[k] <= bnd_hi[k];
                end
                r_ix  <= bnd_lo[0][IDX_W-1:0];
                r_iy  <= bnd_lo[1][IDX_W-1:0];
                r_iz  <= bnd_lo[2][IDX_W-1:0];
                r_ax  <= 2'd0;
                r_acc <= '0;
            end
            ST_POS: begin
                r_mag <= pos_diff[D_W-1] ? MAG_W'(-pos_diff) : MAG_W'(pos_diff);
                r_pt  <= 2'd0;
            end
            ST_ACC: begin
                r_acc <= r_acc + acc_add;
                if (r_pt != 2'd2) begin
                    r_pt <= r_pt + 2'd1;
                end else begin
                    r_ax <= r_ax + 2'd1;
                end
            end
            ST_SQW: if (sq_done) r_dist <= sq_root;
            ST_SDF: begin
                r_sneg <= sneg_c;
                r_smag <= sdf[SDF_W-1] ? ROOT_W'(-sdf) : ROOT_W'(sdf);
            end
            ST_SC1: r_full <= r_prod;
            ST_SC2: r_v <= r_sneg ? (32'd0 - q32) : q32;
            ST_UPD: begin
                r_ax  <= 2'd0;
                r_acc <= '0;
                if (r_ix != r_hi[0][IDX_W-1:0]) begin
                    r_ix <= r_ix + IDX_W'(1);
                end else begin
                    r_ix <= r_lo[0][IDX_W-1:0];
                    if (r_iy != r_hi[1][IDX_W-1:0]) begin
                        r_iy <= r_iy + IDX_W'(1);
                    end else begin
                        r_iy <= r_lo[1][IDX_W-1:0];
                        r_iz <= r_iz + IDX_W'(1);
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    o_read_value  <= r_rv;
                    o_dirty_valid <= r_dflag;
                    o_dirty_min_x <= r_dlo[0];
                    o_dirty_min_y <= r_dlo[1];
                    o_dirty_min_z <= r_dlo[2];
                    o_dirty_max_x <= r_dhi[0];
                    o_dirty_max_y <= r_dhi[1];
                    o_dirty_max_z <= r_dhi[2];
                end
            end
            default: ;
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_DEC))
        else $error("accepted item was not decoded");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIVW))
        else $error("divider finished while the sequencer was not waiting");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_IDLE))
        else $error("voxel memory written while idle");

    a_clean_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dflag |-> (r_dlo[0] == 0 && r_dlo[1] == 0 && r_dlo[2] == 0
                   && r_dhi[0] == 0 && r_dhi[1] == 0 && r_dhi[2] == 0))
        else $error("dirty box not zero while no box is recorded");

endmodule

>>> dv/vss_checker.sv
`timescale 1ns / 100ps

module vss_checker
    import vss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [31:0]              pwdata,
    input  logic                     i_valid,
    input  logic                     o_ready,
    input  logic [2:0]               i_opcode,
    input  logic signed [31:0]       i_center_x,
    input  logic signed [31:0]       i_center_y,
    input  logic signed [31:0]       i_center_z,
    input  logic [30:0]              i_radius,
    input  logic signed [31:0]       i_strength,
    input  logic signed [15:0]       i_voxel_x,
    input  logic signed [15:0]       i_voxel_y,
    input  logic signed [15:0]       i_voxel_z,
    input  logic signed [31:0]       i_write_value,
    input  logic                     o_valid,
    input  logic                     i_ready,
    input  logic signed [31:0]       o_read_value,
    input  logic                     o_dirty_valid,
    input  logic signed [15:0]       o_dirty_min_x,
    input  logic signed [15:0]       o_dirty_min_y,
    input  logic signed [15:0]       o_dirty_min_z,
    input  logic signed [15:0]       o_dirty_max_x,
    input  logic signed [15:0]       o_dirty_max_y,
    input  logic signed [15:0]       o_dirty_max_z,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [31:0] rv;
        logic        dv;
        logic [15:0] lx, ly, lz, hx, hy, hz;
    } sculpt_result_t;

    sculpt_result_t result_q[$];

    longint org[3];
    longint cel[3];
    int     gsz;
    int     sdf_grid[VOX_COUNT];
    bit     box_on;
    int     box_lo[3];
    int     box_hi[3];

    task automatic clear_state();
        for (int i = 0; i < VOX_COUNT; i++) sdf_grid[i] = 65536;
        box_on = 0;
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = 0;
            box_hi[k] = 0;
            org[k]    = 0;
            cel[k]    = 2114;
        end
        gsz = 32;
    endtask

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint dist_q16(longint dx, longint dy, longint dz);
        logic [127:0] sum, t, r;
        sum = 128'(mag64(dx)) * 128'(mag64(dx)) + 128'(mag64(dy)) * 128'(mag64(dy))
            + 128'(mag64(dz)) * 128'(mag64(dz));
        r = 0;
        for (int b = 41; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= sum) r = t;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic int scale_clip(longint sdf, longint s);
        bit           neg;
        logic [127:0] p, q, lim;
        neg = (sdf < 0) != (s < 0);
        p   = 128'(mag64(sdf)) * 128'(mag64(s));
        q   = p >> 16;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) q = lim;
        return neg ? -int'(q[31:0]) : int'(q[31:0]);
    endfunction

    function automatic longint grid_int(longint v);
        return v >= 0 ? (v >>> 16) : -((-v) >>> 16);
    endfunction

    function automatic int clip16(longint v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : int'(v));
    endfunction

    function automatic longint used_n();
        return gsz > GRID_SIZE ? GRID_SIZE : gsz;
    endfunction

    task automatic carve(bit sub, longint cx, longint cy, longint cz, longint rad, longint s);
        longint c[3], lo[3], hi[3], gr, gc, n, sdf;
        int     v, idx, a, b;
        c[0] = cx; c[1] = cy; c[2] = cz;
        n  = used_n();
        gr = rad * 65536 / cel[0];
        for (int k = 0; k < 3; k++) begin
            gc = (c[k] - org[k]) * 65536 / cel[k];
            lo[k] = grid_int(gc - gr) - 1;
            hi[k] = grid_int(gc + gr) + 1;
            if (lo[k] < 0) lo[k] = 0;
            if (hi[k] > n - 1) hi[k] = n - 1;
        end
        for (longint z = lo[2]; z <= hi[2]; z++)
            for (longint y = lo[1]; y <= hi[1]; y++)
                for (longint x = lo[0]; x <= hi[0]; x++) begin
                    sdf = dist_q16(org[0] + x * cel[0] - c[0], org[1] + y * cel[1] - c[1],
                                   org[2] + z * cel[2] - c[2]) - rad;
                    if (sub) sdf = -sdf;
                    v   = scale_clip(sdf, s);
                    idx = int'((z * GRID_SIZE + y) * GRID_SIZE + x);
                    if (sub ? (v > sdf_grid[idx]) : (v < sdf_grid[idx])) sdf_grid[idx] = v;
                end
        for (int k = 0; k < 3; k++) begin
            a = clip16(lo[k]);
            b = clip16(hi[k]);
            if (!box_on || a < box_lo[k]) box_lo[k] = a;
            if (!box_on || b > box_hi[k]) box_hi[k] = b;
        end
        box_on = 1;
    endtask

    task automatic predict();
        sculpt_result_t e;
        longint         vx, vy, vz, n;
        int             rv, idx;
        bit             inb;
        vx = i_voxel_x; vy = i_voxel_y; vz = i_voxel_z;
        n  = used_n();
        rv = 0;
        inb = vx >= 0 && vx < n && vy >= 0 && vy < n && vz >= 0 && vz < n;
        case (i_opcode)
            OP_ADD, OP_SUB: carve(i_opcode == OP_SUB, i_center_x, i_center_y, i_center_z,
                                  longint'(i_radius), i_strength);
            OP_READ, OP_WRITE: begin
                if (inb) begin
                    idx = int'((vz * GRID_SIZE + vy) * GRID_SIZE + vx);
                    if (i_opcode == OP_WRITE) sdf_grid[idx] = i_write_value;
                    rv = sdf_grid[idx];
                end else begin
                    rv = 65536;
                end
            end
            OP_CLEAR: begin
                box_on = 0;
                for (int k = 0; k < 3; k++) begin
                    box_lo[k] = 0;
                    box_hi[k] = 0;
                end
            end
            default: ;
        endcase
        e.rv = rv;
        e.dv = box_on;
        e.lx = box_lo[0][15:0]; e.ly = box_lo[1][15:0]; e.lz = box_lo[2][15:0];
        e.hx = box_hi[0][15:0]; e.hy = box_hi[1][15:0]; e.hz = box_hi[2][15:0];
        result_q.push_back(e);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    task automatic compare_result();
        sculpt_result_t e;
        if (result_q.size() == 0) begin
            report("unexpected item", 1, 0);
            return;
        end
        e = result_q.pop_front();
        if (o_read_value != signed'(e.rv)) report("read_value", o_read_value, signed'(e.rv));
        if (o_dirty_valid != e.dv) report("dirty_valid", o_dirty_valid, e.dv);
        if (o_dirty_min_x != signed'(e.lx)) report("dirty_min_x", o_dirty_min_x, signed'(e.lx));
        if (o_dirty_min_y != signed'(e.ly)) report("dirty_min_y", o_dirty_min_y, signed'(e.ly));
        if (o_dirty_min_z != signed'(e.lz)) report("dirty_min_z", o_dirty_min_z, signed'(e.lz));
        if (o_dirty_max_x != signed'(e.hx)) report("dirty_max_x", o_dirty_max_x, signed'(e.hx));
        if (o_dirty_max_y != signed'(e.hy)) report("dirty_max_y", o_dirty_max_y, signed'(e.hy));
        if (o_dirty_max_z != signed'(e.hz)) report("dirty_max_z", o_dirty_max_z, signed'(e.hz));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                // A zero spacing behaves as one.
                case (paddr[4:2])
                    REG_ORIGIN_X: org[0] = longint'(signed'(pwdata));
                    REG_ORIGIN_Y: org[1] = longint'(signed'(pwdata));
                    REG_ORIGIN_Z: org[2] = longint'(signed'(pwdata));
                    REG_CELL_X:   cel[0] = pwdata[30:0] == 0 ? 1 : longint'(pwdata[30:0]);
                    REG_CELL_Y:   cel[1] = pwdata[30:0] == 0 ? 1 : longint'(pwdata[30:0]);
                    REG_CELL_Z:   cel[2] = pwdata[30:0] == 0 ? 1 : longint'(pwdata[30:0]);
                    REG_GRID:     gsz = int'(pwdata[5:0]);
                    default: ;
                endcase
            end
            if (o_valid && i_ready) compare_result();
            if (i_valid && o_ready) predict();
        end
        o_pending <= result_q.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vss_pkg::*;

    logic               i_clk, i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [CFG_AW-1:0]  paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_ready, o_valid, i_ready;
    logic [2:0]         i_opcode;
    logic signed [31:0] i_center_x, i_center_y, i_center_z, i_strength, i_write_value;
    logic [30:0]        i_radius;
    logic signed [15:0] i_voxel_x, i_voxel_y, i_voxel_z;
    logic signed [31:0] o_read_value;
    logic               o_dirty_valid;
    logic signed [15:0] o_dirty_min_x, o_dirty_min_y, o_dirty_min_z;
    logic signed [15:0] o_dirty_max_x, o_dirty_max_y, o_dirty_max_z;
    int                 fail_count, pending;

    int     src_pct, snk_pct;
    int     n_items, n_carves, n_settings;
    longint cur_org[3], cur_cel[3];
    int     cur_n;

    voxel_sdf_sphere_sculpt uut (.*);
    vss_checker chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("[voxel_sdf_sphere_sculpt] ERROR");
        $finish;
    end

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= snk_pct);

    task automatic push(logic [2:0] op, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                        logic [30:0] r, logic [31:0] s, logic [15:0] vx, logic [15:0] vy,
                        logic [15:0] vz, logic [31:0] wv);
        @(negedge i_clk);
        if ($urandom_range(99) < src_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
            while ($urandom_range(99) < src_pct) @(negedge i_clk);
        end
        i_opcode <= op;  i_center_x <= cx; i_center_y <= cy; i_center_z <= cz;
        i_radius <= r;   i_strength <= s;  i_voxel_x <= vx;  i_voxel_y <= vy;
        i_voxel_z <= vz; i_write_value <= wv;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
        if (op == OP_ADD || op == OP_SUB) n_carves++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [30:0] cx, logic [30:0] cy, logic [30:0] cz,
                             logic [5:0] g);
        reg_write(REG_ORIGIN_X, ox); reg_write(REG_ORIGIN_Y, oy); reg_write(REG_ORIGIN_Z, oz);
        reg_write(REG_CELL_X, cx);   reg_write(REG_CELL_Y, cy);   reg_write(REG_CELL_Z, cz);
        reg_write(REG_GRID, g);
        cur_org[0] = signed'(ox); cur_org[1] = signed'(oy); cur_org[2] = signed'(oz);
        cur_cel[0] = cx == 0 ? 1 : cx;
        cur_cel[1] = cy == 0 ? 1 : cy;
        cur_cel[2] = cz == 0 ? 1 : cz;
        cur_n = g > GRID_SIZE ? GRID_SIZE : g;
        n_settings++;
    endtask

    function automatic logic [31:0] clip32(longint v);
        return v < -64'sd2147483648 ? 32'h8000_0000 : (v > 64'sd2147483647 ? 32'h7fff_ffff : v[31:0]);
    endfunction

    // Center near a random voxel of the active grid, so that the region is small but real.
    function automatic logic [31:0] near_center(int k);
        longint g;
        g = cur_n > 0 ? $urandom_range(cur_n - 1) : 0;
        return clip32(cur_org[k] + g * cur_cel[k] + longint'($urandom) % cur_cel[k]);
    endfunction

    function automatic logic [15:0] pick_index();
        if (cur_n > 0 && $urandom_range(99) < 80) return 16'($urandom_range(cur_n - 1));
        return 16'($urandom);
    endfunction

    task automatic random_item();
        int          roll;
        logic [2:0]  op;
        logic [31:0] cx, cy, cz;
        longint      r;
        roll = $urandom_range(99);
        op = roll < 35 ? (roll[0] ? OP_SUB : OP_ADD) : roll < 60 ? OP_READ :
             roll < 82 ? OP_WRITE : roll < 92 ? OP_BOX : OP_CLEAR;
        if ((op == OP_ADD || op == OP_SUB) && $urandom_range(99) < 75) begin
            cx = near_center(0); cy = near_center(1); cz = near_center(2);
            r  = longint'($urandom) % (2 * cur_cel[0] + 1);
        end else begin
            cx = $urandom; cy = $urandom; cz = $urandom;
            // Unbounded radii only where the grid is tiny, otherwise the walk is long.
            r = cur_n <= 4 ? longint'($urandom) : longint'($urandom) % cur_cel[0];
        end
        if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
        push(op, cx, cy, cz, 31'(r), $urandom, pick_index(), pick_index(), pick_index(),
             $urandom);
    endtask

    task automatic random_run(int count);
        repeat (count) random_item();
        wait_idle();
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_valid = 0; i_ready = 0; i_opcode = OP_BOX;
        i_center_x = 0; i_center_y = 0; i_center_z = 0; i_radius = 0; i_strength = 0;
        i_voxel_x = 0; i_voxel_y = 0; i_voxel_z = 0; i_write_value = 0;
        src_pct = 0; snk_pct = 0; n_items = 0; n_carves = 0; n_settings = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed part at the reset settings.
        cur_org = '{0, 0, 0}; cur_cel = '{2114, 2114, 2114}; cur_n = 32;
        push(OP_BOX,   0, 0, 0, 0, 0, 0, 0, 0, 0);
        push(OP_READ,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        push(OP_WRITE, 0, 0, 0, 0, 0, 31, 31, 31, 32'h7fff_ffff);
        push(OP_READ,  0, 0, 0, 0, 0, 31, 31, 31, 0);
        push(OP_WRITE, 0, 0, 0, 0, 0, 16'hffff, 0, 0, 32'h1234_5678);
        push(OP_WRITE, 0, 0, 0, 0, 0, 5, 32, 5, 32'h1234_5678);
        push(OP_READ,  0, 0, 0, 0, 0, 16'h8000, 16'h7fff, 0, 0);
        push(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
        push(OP_ADD, 3 * 2114 + 100, 3 * 2114, 3 * 2114, 2114, 32'h0001_0000, 0, 0, 0, 0);
        push(OP_SUB, 4 * 2114, 4 * 2114 + 7, 4 * 2114, 2114, 32'hffff_0000, 0, 0, 0, 0);
        push(OP_ADD, 6 * 2114, 6 * 2114, 6 * 2114, 0, 32'h7fff_ffff, 0, 0, 0, 0);
        push(OP_SUB, 2114, 2114, 2114, 1500, 32'h8000_0000, 0, 0, 0, 0);
        push(OP_BOX,   0, 0, 0, 0, 0, 0, 0, 0, 0);
        push(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h0001_0000, 0, 0, 0, 0);
        push(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 100, 0, 0, 0, 0, 0);
        push(OP_READ,  0, 0, 0, 0, 0, 3, 3, 3, 0);
        push(OP_READ,  0, 0, 0, 0, 0, 0, 0, 0, 0);
        push(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push(OP_BOX,   0, 0, 0, 0, 0, 0, 0, 0, 0);
        random_run(30);

        // Extreme origins and spacings on a two voxel grid, zero spacing on z.
        src_pct = 74;
        configure(32'h8000_0000, 32'h7fff_ffff, 32'h0001_2345, 31'd1, 31'h7fff_ffff, 31'd0, 6'd2);
        push(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 0, 31'h7fff_ffff, 32'h0000_8000, 0, 0, 0, 0);
        push(OP_SUB, 32'h8000_0001, 32'h7fff_fff0, 32'h0001_2345, 31'h7fff_ffff, 32'hffff_ffff,
             0, 0, 0, 0);
        random_run(20);

        // Grid size above the built size is clamped.
        src_pct = 0; snk_pct = 74;
        configure(32'hfffe_0000, 32'h0000_3000, 32'hffff_fff0, 31'd4096, 31'd3000, 31'd65536, 6'd63);
        random_run(25);

        src_pct = 32; snk_pct = 32;
        configure(0, 0, 0, 31'd2114, 31'd2114, 31'd2114, 6'd5);
        random_run(25);

        // Degenerate grids: one voxel, then none at all.
        configure(0, 0, 0, 31'd65536, 31'd65536, 31'd65536, 6'd1);
        random_run(8);
        configure(0, 0, 0, 31'd65536, 31'd65536, 31'd65536, 6'd0);
        random_run(8);

        repeat (20) @(posedge i_clk);
        $display("Sent %0d items, %0d of them sphere edits, over %0d register settings",
                 n_items, n_carves, n_settings + 1);
        $display("with sender gaps and receiver stalls at 0, 32 and 74 percent.");
        if (fail_count == 0) begin
            $display("[voxel_sdf_sphere_sculpt] OK");
        end else begin
            $display("[voxel_sdf_sphere_sculpt] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/vss_pkg.sv
design/vss_div.sv
design/vss_sqrt.sv
design/voxel_sdf_sphere_sculpt.sv
dv/vss_checker.sv
dv/tb_top.sv
